// ===== sv/tpd_pkg.sv =====
`default_nettype none

package tpd_pkg;

    // Packet framing constants.
    localparam int STORE_DEPTH = 9;
    localparam int COUNT_W     = 4;
    localparam logic [COUNT_W-1:0] PKT_MIN_LEN = COUNT_W'(7);
    localparam logic [COUNT_W-1:0] PKT_TILT_LEN = COUNT_W'(8);
    localparam logic [COUNT_W-1:0] PKT_MAX_LEN = COUNT_W'(STORE_DEPTH);

    // Bit positions inside the packet bytes.
    localparam int SYNC_BIT = 7;
    localparam int PROX_BIT = 3;

    localparam int MASK_W  = 9;
    localparam int OUT_W   = 72;
    localparam int VALUE_W = 58;

    typedef logic [STORE_DEPTH-1:0][7:0] store_t;

    // Decoded tablet values, one full set per packet.
    typedef struct packed {
        logic [3:0]         button_bits;
        logic signed [6:0]  tilt_vert;
        logic signed [6:0]  tilt_horiz;
        logic [7:0]         pressure;
        logic [15:0]        pos_y;
        logic [15:0]        pos_x;
    } values_t;

    // Outcome of decoding the held packet against the last values.
    typedef struct packed {
        logic                valid;
        logic [MASK_W-1:0]   changed_mask;
        values_t             values;
    } decode_t;

endpackage

`default_nettype wire

// ===== sv/tablet_packet_decoder_core.sv =====
`default_nettype none

// Pen tablet serial packet decoder.
// The slave channel takes one received serial byte per item in s_tdata[7:0].
// A byte with bit 7 set starts a packet; up to nine bytes are held, and
// extra bytes are dropped. When the next start byte arrives and the held
// packet has at least seven bytes, it is decoded into x, y, pressure, tilt
// and buttons. If any value differs from the last decoded one, a single
// item leaves on the master channel with a mask of the changed fields and
// all current values; otherwise nothing is sent for that packet.
// A start byte that closes a packet moves from the input register through the
// decode into the result register, which drives m_tvalid.
// Throughput is one byte per cycle while the receiver does not stall; the
// decode is a single pass of bit extraction and compares against the last
// values.
// Reset clears the packet store, the byte count and the last values, and
// empties both registers. While the receiver stalls, the result register
// holds and one more byte waits in the input register, then s_tready drops.
module tablet_packet_decoder_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // [8:0] changed_mask, [24:9] pos_x,
                                        // [40:25] pos_y, [48:41] pressure,
                                        // [55:49] tilt_horiz, [62:56] tilt_vert,
                                        // [66:63] button_bits, [71:67] zero
);
    import tpd_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    store_t                store_reg;
    logic [COUNT_W-1:0]    count_reg;
    values_t               last_reg;
    logic                  out_valid_reg;
    logic [MASK_W-1:0]     out_mask_reg;
    values_t               out_values_reg;

    decode_t               dec;
    logic                  proc;
    logic                  is_sync;
    logic                  emit;

    tpd_decode u_decode (
        .store       (store_reg),
        .byte_count  (count_reg),
        .last_values (last_reg),
        .result      (dec)
    );

    // Handshake: the held byte is processed whenever the result slot is free or being drained.
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;
    assign is_sync  = in_byte_reg[SYNC_BIT];
    assign emit     = proc && is_sync && dec.valid && (dec.changed_mask != '0);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Packet store, byte count and last decoded values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            count_reg <= '0;
            last_reg  <= '0;
        end
        else if (proc)
        begin
            if (is_sync)
            begin
                if (dec.valid)
                begin
                    last_reg <= dec.values;
                end
                store_reg[0] <= in_byte_reg;
                count_reg    <= COUNT_W'(1);
            end
            else if (count_reg < PKT_MAX_LEN)
            begin
                store_reg[count_reg] <= in_byte_reg;
                count_reg            <= count_reg + COUNT_W'(1);
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_mask_reg   <= dec.changed_mask;
            out_values_reg <= dec.values;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - VALUE_W - MASK_W)'(0), out_values_reg, out_mask_reg};

    // The byte count never runs past the store depth.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= PKT_MAX_LEN)
        else $error("byte count beyond packet store depth");

    // A result always reports at least one changed field.
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> (m_tdata[8:0] != '0))
        else $error("result with empty change mask");

    // A processed start byte restarts the packet at one byte.
    assert property (@(posedge clk) disable iff (!rst_n) (proc && is_sync) |=> count_reg == 1)
        else $error("start byte did not restart packet");

    // A new result is only loaded when the slot is free or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!$past(out_valid_reg) || !out_valid_reg || m_tready))
        else $error("result loaded over a stalled result");

endmodule

`default_nettype wire

// ===== sv/tpd_decode.sv =====
`default_nettype none

module tpd_decode (
    input  wire tpd_pkg::store_t                  store,
    input  wire logic [tpd_pkg::COUNT_W-1:0]      byte_count,
    input  wire tpd_pkg::values_t                 last_values,
    output tpd_pkg::decode_t                      result
);
    import tpd_pkg::*;

    values_t           cur;
    logic [MASK_W-1:0] mask;

    // Field extraction from the held packet bytes.
    always_comb
    begin
        cur.pos_x       = {store[0][1:0], store[1][6:0], store[2][6:0]};
        cur.pos_y       = {store[3][1:0], store[4][6:0], store[5][6:0]};
        cur.pressure    = {~store[6][6], store[6][5:0], store[3][2]};
        cur.button_bits = store[0][PROX_BIT] ? store[3][6:3] : 4'd0;
        if (byte_count >= PKT_TILT_LEN)
        begin
            cur.tilt_horiz = $signed(store[7][6:0]);
            cur.tilt_vert  = $signed(store[8][6:0]);
        end
        else
        begin
            cur.tilt_horiz = 7'sd0;
            cur.tilt_vert  = 7'sd0;
        end
    end

    // Compare with the last reported values to build the change mask.
    always_comb
    begin
        mask[0]   = cur.pos_x != last_values.pos_x;
        mask[1]   = cur.pos_y != last_values.pos_y;
        mask[2]   = cur.pressure != last_values.pressure;
        mask[3]   = cur.tilt_horiz != last_values.tilt_horiz;
        mask[4]   = cur.tilt_vert != last_values.tilt_vert;
        mask[8:5] = cur.button_bits ^ last_values.button_bits;
    end

    always_comb
    begin
        result.valid        = byte_count >= PKT_MIN_LEN;
        result.changed_mask = mask;
        result.values       = cur;
    end

endmodule

`default_nettype wire
